### rtl/pfra_pkg.sv
// pfra_pkg: shared constants, types and helpers for the page frame
// reference-count allocator. No dependencies.
package pfra_pkg;

    // pool geometry
    localparam int FRAMES      = 32768;
    localparam int PAGE_SHIFT  = 12;
    localparam int COUNT_WIDTH = 8;

    localparam int ADDR_W = 32;
    localparam int IDX_W  = $clog2(FRAMES);
    localparam int FREE_W = $clog2(FRAMES + 1);

    localparam logic [ADDR_W-1:0]      POOL_BASE_RESET = 32'h0100_0000;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX         = '1;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_SHARE = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_COUNT = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_RMW,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] frame_address;
        status_t           status;
        logic [15:0]       free_count;
    } result_t;

    // free total clipped to the 16-bit result field
    function automatic logic [15:0] sat_free(input logic [FREE_W-1:0] total);
        logic [31:0] wide;
        wide = 32'(total);
        return (wide > 32'd65535) ? 16'hFFFF : wide[15:0];
    endfunction

endpackage

### rtl/pfra_count_ram.sv
// pfra_count_ram: per-frame reference count store, one write and one
// registered read port. Depends on pfra_pkg.
module pfra_count_ram (
    input  logic                            aclk,
    input  logic                            wr_en,
    input  logic [pfra_pkg::IDX_W-1:0]       wr_addr,
    input  logic [pfra_pkg::COUNT_WIDTH-1:0] wr_data,
    input  logic                            rd_en,
    input  logic [pfra_pkg::IDX_W-1:0]       rd_addr,
    output logic [pfra_pkg::COUNT_WIDTH-1:0] rd_data
);
    import pfra_pkg::*;

    logic [COUNT_WIDTH-1:0] mem [FRAMES];
    logic [COUNT_WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/pfra_ctrl.sv
// pfra_ctrl: command sequencer for the allocator: clearing pass, address
// decode, first-fit scan and read-modify-write of the count store.
// Depends on pfra_pkg and pfra_count_ram.
module pfra_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [pfra_pkg::ADDR_W-1:0] pool_base,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 in_command,
    input  logic [pfra_pkg::ADDR_W-1:0] in_address,
    output logic                       res_valid,
    input  logic                       res_ready,
    output pfra_pkg::result_t          res
);
    import pfra_pkg::*;

    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        clr_cnt_reg, clr_cnt_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [ADDR_W-1:0]       addr_reg, addr_next;
    logic [IDX_W-1:0]        frame_reg, frame_next;
    logic [FREE_W-1:0]       free_total_reg, free_total_next;
    logic [ADDR_W-1:0]       faddr_reg, faddr_next;
    status_t                 status_reg, status_next;

    logic                    ram_wr_en;
    logic [IDX_W-1:0]        ram_wr_addr;
    logic [COUNT_WIDTH-1:0]  ram_wr_data;
    logic                    ram_rd_en;
    logic [IDX_W-1:0]        ram_rd_addr;
    logic [COUNT_WIDTH-1:0]  ram_rd_data;

    logic [ADDR_W-1:0]       offset;
    logic [ADDR_W-1:0]       offset_hi;
    logic                    out_of_pool;
    logic [IDX_W-1:0]        decoded_frame;
    logic                    clr_last;
    logic                    cnt_zero;

    pfra_count_ram u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // address to frame number
    assign offset        = addr_reg - pool_base;
    assign offset_hi     = offset >> PAGE_SHIFT;
    assign out_of_pool   = (addr_reg < pool_base) || (offset_hi >= 32'(FRAMES));
    assign decoded_frame = offset_hi[IDX_W-1:0];
    assign clr_last      = (clr_cnt_reg == IDX_W'(FRAMES - 1));
    assign cnt_zero      = (ram_rd_data == '0);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (cmd_reg)
                    CMD_ALLOC: state_next = (free_total_reg == '0) ? ST_RESULT : ST_SCAN;
                    CMD_FREE,
                    CMD_SHARE: state_next = out_of_pool ? ST_RESULT : ST_RMW;
                    default:   state_next = ST_RESULT;
                endcase
            end
            ST_SCAN: begin
                if (cnt_zero) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RMW: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // datapath and memory control
    always_comb begin
        clr_cnt_next    = clr_cnt_reg;
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        frame_next      = frame_reg;
        free_total_next = free_total_reg;
        faddr_next      = faddr_reg;
        status_next     = status_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = frame_reg;
        ram_wr_data     = '0;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = frame_reg;
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                // zero one entry per cycle
                ram_wr_en    = 1'b1;
                ram_wr_addr  = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd_next  = cmd_t'(in_command);
                    addr_next = in_address;
                end
            end
            ST_DECODE: begin
                faddr_next  = '0;
                status_next = STAT_OK;
                case (cmd_reg)
                    CMD_ALLOC: begin
                        // start the scan at frame zero
                        frame_next  = '0;
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        if (free_total_reg == '0) begin
                            status_next = STAT_FULL;
                        end
                    end
                    CMD_FREE,
                    CMD_SHARE: begin
                        frame_next  = decoded_frame;
                        ram_rd_en   = !out_of_pool;
                        ram_rd_addr = decoded_frame;
                        if (out_of_pool) begin
                            status_next = STAT_RANGE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_SCAN: begin
                // read data belongs to frame_reg
                if (cnt_zero) begin
                    ram_wr_en       = 1'b1;
                    ram_wr_addr     = frame_reg;
                    ram_wr_data     = COUNT_WIDTH'(1);
                    free_total_next = free_total_reg - 1'b1;
                    faddr_next      = pool_base + (32'(frame_reg) << PAGE_SHIFT);
                end else begin
                    frame_next  = frame_reg + 1'b1;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = frame_reg + 1'b1;
                end
            end
            ST_RMW: begin
                ram_wr_addr = frame_reg;
                if (cmd_reg == CMD_FREE) begin
                    if (cnt_zero) begin
                        status_next = STAT_COUNT;
                    end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = ram_rd_data - 1'b1;
                        if (ram_rd_data == COUNT_WIDTH'(1)) begin
                            free_total_next = free_total_reg + 1'b1;
                        end
                    end
                end else begin
                    if (ram_rd_data == CNT_MAX) begin
                        status_next = STAT_COUNT;
                    end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = ram_rd_data + 1'b1;
                        if (cnt_zero) begin
                            free_total_next = free_total_reg - 1'b1;
                        end
                    end
                end
            end
            ST_RESULT: begin
                res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign res.frame_address = faddr_reg;
    assign res.status        = status_reg;
    assign res.free_count    = sat_free(free_total_reg);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            free_total_reg <= FREE_W'(FRAMES);
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            free_total_reg <= free_total_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        addr_reg   <= addr_next;
        frame_reg  <= frame_next;
        faddr_reg  <= faddr_next;
        status_reg <= status_next;
    end

endmodule

### rtl/page_frame_refcount_allocator_top.sv
// page_frame_refcount_allocator_top: pool base register, command
// sequencer and output register. Depends on pfra_pkg and pfra_ctrl.
//
//  channel   direction  handshake          payload
//  cfg       in         cfg_wr_en          cfg_wr_data (pool base)
//  s_        in         s_valid/s_ready    s_command, s_address
//  m_        out        m_valid/m_ready    m_frame_address, m_status, m_free_count
//
// one command at a time; after accept a query passes decode and result, free
// and share decode, read-modify-write and result, allocate decode, the
// one-entry-per-cycle scan of the count memory up to the lowest free frame,
// and result; an address outside the pool or a full pool goes from decode
// straight to result. after reset a clearing pass zeroes all FRAMES (32768)
// count entries; no command is accepted until it ends, config writes still
// are. the output register holds a result while m_ready is low; the next
// command is accepted meanwhile and waits in the sequencer once done.
module page_frame_refcount_allocator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_frame_address,
    output logic [1:0]  m_status,
    output logic [15:0] m_free_count
);
    import pfra_pkg::*;

    logic [ADDR_W-1:0] pool_base_reg;
    logic              m_valid_reg, m_valid_next;
    result_t           m_result_reg;
    logic              res_valid;
    logic              res_ready;
    result_t           res;

    // pool base register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg <= POOL_BASE_RESET;
        end else if (cfg_wr_en) begin
            pool_base_reg <= cfg_wr_data;
        end
    end

    pfra_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pool_base  (pool_base_reg),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_command (s_command),
        .in_address (s_address),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // output register
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_result_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_frame_address = m_result_reg.frame_address;
    assign m_status        = m_result_reg.status;
    assign m_free_count    = m_result_reg.free_count;

`ifndef SYNTH
    // a finished result stays offered until the output register takes it
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res_ready |=> res_valid)
        else $error("sequencer dropped a pending result");

    // no new transaction is taken while a result is still pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !res_valid)
        else $error("input accepted with a result pending");

    // failed commands report no frame address
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STAT_OK) |-> (m_frame_address == '0))
        else $error("frame address set on a failed command");

    // free count never exceeds the pool size
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_free_count) <= 32'(FRAMES)))
        else $error("free count above pool size");
`endif

endmodule
